### src/lcsf_pkg.sv
// Shared types and constants for the load cell sample filter.
`default_nettype none

package lcsf_pkg;

  localparam int RAW_W      = 24;
  localparam int OFF_W      = 25;
  localparam int SCALE_W    = 32;
  localparam int DIFF_W     = 26;
  localparam int WEIGHT_W   = 42;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LBS_PER_COUNT = 2'd1;

  localparam logic signed [OFF_W-1:0] GLITCH_POS = 25'sh07F_FFFF;
  localparam logic signed [OFF_W-1:0] GLITCH_NEG = 25'sh180_0000;
  localparam logic signed [OFF_W-1:0] MINUS_ONE  = 25'sh1FF_FFFF;
  localparam logic signed [OFF_W-1:0] MAG_MIN    = 25'sd100;
  localparam logic signed [OFF_W-1:0] MAG_MAX    = 25'sd8000000;

  localparam logic signed [RAW_W-1:0] CODE_MAX = 24'sh7F_FFFF;
  localparam logic signed [RAW_W-1:0] CODE_MIN = 24'sh80_0000;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd429497;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_GLITCH = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic                     full;
    logic signed [RAW_W-1:0]  code;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [RAW_W-1:0]  filt;
    logic signed [DIFF_W-1:0] diff;
  } res_t;

endpackage

`default_nettype wire

### src/lcsf_window.sv
// Code checks, ring window with running sum, and first pipeline register.
`default_nettype none

module lcsf_window #(
  parameter int WINDOW_LEN = 10,
  parameter int SUM_W      = 29,
  parameter int SLOT_W     = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [lcsf_pkg::RAW_W-1:0]             in_raw_code,
  input  logic                                   fill_en,
  input  logic signed [lcsf_pkg::RAW_W-1:0]      fill_val,
  output logic                                   s1_valid,
  input  logic                                   s1_ready,
  output lcsf_pkg::item_t                        s1_item,
  output logic signed [SUM_W-1:0]                s1_sum
);

  localparam logic [SLOT_W-1:0]       SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
  localparam logic signed [SUM_W-1:0] WIN_LEN_S = SUM_W'(WINDOW_LEN);

  logic signed [lcsf_pkg::RAW_W-1:0] win_r [WINDOW_LEN];
  logic [SLOT_W-1:0]                 slot_r;
  logic                              full_r;
  logic signed [SUM_W-1:0]           sum_r;
  logic                              s1_valid_r;
  lcsf_pkg::item_t                   item_r;
  logic signed [SUM_W-1:0]           s1_sum_r;

  logic signed [lcsf_pkg::OFF_W-1:0] code_ext;
  logic signed [lcsf_pkg::OFF_W-1:0] neg_code;
  logic signed [lcsf_pkg::OFF_W-1:0] mag;
  logic signed [lcsf_pkg::RAW_W-1:0] code24;
  logic signed [lcsf_pkg::RAW_W-1:0] old_val;
  lcsf_pkg::status_t                 status;
  logic                              load;
  logic                              take;
  logic                              keep;
  logic                              wrap;
  logic [SLOT_W-1:0]                 slot_nxt;
  logic signed [SUM_W-1:0]           sum_nxt;
  logic signed [SUM_W-1:0]           fill_sum;

  always_comb begin
    code_ext = $signed({in_raw_code[lcsf_pkg::RAW_W-1], in_raw_code});
    neg_code = -code_ext;
    mag      = neg_code[lcsf_pkg::OFF_W-1] ? -neg_code : neg_code;
    code24   = $signed(neg_code[lcsf_pkg::RAW_W-1:0]);
    priority if (neg_code == '0 || neg_code == lcsf_pkg::MINUS_ONE ||
                 neg_code == lcsf_pkg::GLITCH_POS || neg_code == lcsf_pkg::GLITCH_NEG) begin
      status = lcsf_pkg::ST_GLITCH;
    end else if (mag < lcsf_pkg::MAG_MIN || mag > lcsf_pkg::MAG_MAX) begin
      status = lcsf_pkg::ST_RANGE;
    end else begin
      status = lcsf_pkg::ST_OK;
    end
  end

  assign load     = !s1_valid_r || s1_ready;
  assign in_stall = !load;
  assign take     = in_valid && load;
  assign keep     = take && (status == lcsf_pkg::ST_OK);

  assign wrap     = (slot_r == SLOT_LAST);
  assign slot_nxt = wrap ? '0 : slot_r + SLOT_W'(1);
  assign old_val  = win_r[slot_r];
  assign sum_nxt  = sum_r - SUM_W'(old_val) + SUM_W'(code24);
  assign fill_sum = SUM_W'(fill_val) * WIN_LEN_S;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
      slot_r <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
    end else if (fill_en) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= fill_val;
      end
      slot_r <= '0;
      full_r <= 1'b0;
      sum_r  <= fill_sum;
    end else if (keep) begin
      win_r[slot_r] <= code24;
      slot_r        <= slot_nxt;
      full_r        <= full_r | wrap;
      sum_r         <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.status <= status;
      item_r.full   <= full_r | wrap;
      item_r.code   <= code24;
      s1_sum_r      <= sum_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;
  assign s1_sum   = s1_sum_r;

endmodule

`default_nettype wire

### src/lcsf_divide.sv
// Window average by reciprocal multiply and offset subtraction, two stages.
`default_nettype none

module lcsf_divide #(
  parameter int WINDOW_LEN = 10,
  parameter int SUM_W      = 29
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               s1_valid,
  output logic                               s1_ready,
  input  lcsf_pkg::item_t                    s1_item,
  input  logic signed [SUM_W-1:0]            s1_sum,
  input  logic signed [lcsf_pkg::OFF_W-1:0]  zero_offset,
  output logic                               s3_valid,
  input  logic                               s3_ready,
  output lcsf_pkg::res_t                     s3_res
);

  localparam int MAG_W   = SUM_W - 1;
  localparam int LOG_LEN = $clog2(WINDOW_LEN);
  localparam int SHIFT   = MAG_W + LOG_LEN;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic                         s2_valid_r;
  lcsf_pkg::item_t              s2_item_r;
  logic                         s2_neg_r;
  logic [PROD_W-1:0]            s2_prod_r;
  logic                         s3_valid_r;
  lcsf_pkg::res_t               s3_res_r;

  logic                         s2_load;
  logic                         s3_load;
  logic signed [SUM_W-1:0]      sum_neg;
  logic [MAG_W-1:0]             sum_mag;
  logic [PROD_W-1:0]            prod_nxt;
  logic [lcsf_pkg::RAW_W-1:0]   quot;
  logic signed [lcsf_pkg::RAW_W-1:0] quot_s;
  logic signed [lcsf_pkg::RAW_W-1:0] filt;
  logic signed [lcsf_pkg::DIFF_W-1:0] diff;

  assign s3_load  = !s3_valid_r || s3_ready;
  assign s2_load  = !s2_valid_r || s3_load;
  assign s1_ready = s2_load;

  assign sum_neg  = -s1_sum;
  assign sum_mag  = s1_sum[SUM_W-1] ? MAG_W'(sum_neg) : MAG_W'(s1_sum);
  assign prod_nxt = PROD_W'(sum_mag) * PROD_W'(RECIP);

  always_comb begin
    quot   = s2_prod_r[SHIFT +: lcsf_pkg::RAW_W];
    quot_s = s2_neg_r ? $signed(-quot) : $signed(quot);
    filt   = s2_item_r.full ? quot_s : s2_item_r.code;
    diff   = $signed({{2{filt[lcsf_pkg::RAW_W-1]}}, filt}) -
             $signed({zero_offset[lcsf_pkg::OFF_W-1], zero_offset});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_valid_r <= s1_valid;
      end
      if (s3_load) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      s2_item_r <= s1_item;
      s2_neg_r  <= s1_sum[SUM_W-1];
      s2_prod_r <= prod_nxt;
    end
    if (s3_load && s2_valid_r) begin
      s3_res_r.status <= s2_item_r.status;
      s3_res_r.filt   <= filt;
      s3_res_r.diff   <= diff;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_res   = s3_res_r;

endmodule

`default_nettype wire

### src/lcsf_scale.sv
// Scale multiply and result register.
`default_nettype none

module lcsf_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 s3_valid,
  output logic                                 s3_ready,
  input  lcsf_pkg::res_t                       s3_res,
  input  logic [lcsf_pkg::SCALE_W-1:0]         lbs_per_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_accepted,
  output logic [1:0]                           out_status,
  output logic signed [lcsf_pkg::RAW_W-1:0]    out_filtered_count,
  output logic signed [lcsf_pkg::WEIGHT_W-1:0] out_weight
);

  localparam int PROD_W = lcsf_pkg::DIFF_W + lcsf_pkg::SCALE_W + 1;

  logic                                 out_valid_r;
  logic                                 accepted_r;
  lcsf_pkg::status_t                    status_r;
  logic signed [lcsf_pkg::RAW_W-1:0]    filt_r;
  logic signed [lcsf_pkg::WEIGHT_W-1:0] weight_r;

  logic                                 load;
  logic                                 ok;
  logic signed [PROD_W-1:0]             prod;

  assign load     = !out_valid_r || !out_stall;
  assign s3_ready = load;
  assign ok       = (s3_res.status == lcsf_pkg::ST_OK);
  assign prod     = s3_res.diff * $signed({1'b0, lbs_per_count});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && s3_valid) begin
      accepted_r <= ok;
      status_r   <= s3_res.status;
      filt_r     <= ok ? s3_res.filt : '0;
      weight_r   <= ok ? prod[16 +: lcsf_pkg::WEIGHT_W] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = accepted_r;
  assign out_status         = status_r;
  assign out_filtered_count = filt_r;
  assign out_weight         = weight_r;

endmodule

`default_nettype wire

### src/load_cell_sample_filter.sv
// Top level of the load cell sample filter: config registers and pipeline.
//
//  channel | direction | handshake          | payload
//  in      | request   | in_valid/in_stall  | in_raw_code
//  out     | result    | out_valid/out_stall| out_accepted, out_status,
//          |           |                    | out_filtered_count, out_weight
//  cfg     | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle while in_stall is low; its result reaches out through the stages below.
// Register stages: window and sum, divide product, offset subtract, scale multiply.
// A running window sum keeps the per-request window update to one subtract and one add.
// Reset clears the window, sum, slot, full flag and pipeline valids.
// A stall on out backs up stage by stage; in_stall rises only with all four stages full.
// A zero_offset write refills the window in the same cycle.
`default_nettype none

module load_cell_sample_filter #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lcsf_pkg::RAW_W-1:0]            in_raw_code,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_accepted,
  output logic [1:0]                            out_status,
  output logic signed [lcsf_pkg::RAW_W-1:0]     out_filtered_count,
  output logic signed [lcsf_pkg::WEIGHT_W-1:0]  out_weight,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lcsf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int LOG_LEN = $clog2(WINDOW_LEN);
  localparam int SUM_W   = lcsf_pkg::OFF_W + LOG_LEN;
  localparam int SLOT_W  = LOG_LEN;

  logic signed [lcsf_pkg::OFF_W-1:0]  offset_r;
  logic [lcsf_pkg::SCALE_W-1:0]       scale_r;

  logic                               cfg_we;
  logic                               fill_en;
  logic signed [lcsf_pkg::RAW_W-1:0]  fill_val;
  logic [lcsf_pkg::OFF_W-1:0]         cfg_off;

  logic                               s1_valid;
  logic                               s1_ready;
  lcsf_pkg::item_t                    s1_item;
  logic signed [SUM_W-1:0]            s1_sum;
  logic                               s3_valid;
  logic                               s3_ready;
  lcsf_pkg::res_t                     s3_res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign fill_en   = cfg_we && (cfg_index == lcsf_pkg::REG_ZERO_OFFSET);
  assign cfg_off   = cfg_data[lcsf_pkg::OFF_W-1:0];

  always_comb begin
    priority if (!cfg_off[lcsf_pkg::OFF_W-1] && cfg_off[lcsf_pkg::RAW_W-1]) begin
      fill_val = lcsf_pkg::CODE_MAX;
    end else if (cfg_off[lcsf_pkg::OFF_W-1] && !cfg_off[lcsf_pkg::RAW_W-1]) begin
      fill_val = lcsf_pkg::CODE_MIN;
    end else begin
      fill_val = $signed(cfg_off[lcsf_pkg::RAW_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      scale_r  <= lcsf_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcsf_pkg::REG_ZERO_OFFSET:   offset_r <= $signed(cfg_off);
        lcsf_pkg::REG_LBS_PER_COUNT: scale_r  <= cfg_data[lcsf_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lcsf_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W),
    .SLOT_W     (SLOT_W)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_raw_code (in_raw_code),
    .fill_en     (fill_en),
    .fill_val    (fill_val),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_item     (s1_item),
    .s1_sum      (s1_sum)
  );

  lcsf_divide #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_divide (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_item     (s1_item),
    .s1_sum      (s1_sum),
    .zero_offset (offset_r),
    .s3_valid    (s3_valid),
    .s3_ready    (s3_ready),
    .s3_res      (s3_res)
  );

  lcsf_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .s3_valid           (s3_valid),
    .s3_ready           (s3_ready),
    .s3_res             (s3_res),
    .lbs_per_count      (scale_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_status         (out_status),
    .out_filtered_count (out_filtered_count),
    .out_weight         (out_weight)
  );

endmodule

`default_nettype wire

### src/lcsf_checker.sv
// Port-level checks for the load cell sample filter and their binding.
`default_nettype none

module lcsf_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic                                  out_accepted,
  input logic [1:0]                            out_status,
  input logic signed [lcsf_pkg::RAW_W-1:0]     out_filtered_count,
  input logic signed [lcsf_pkg::WEIGHT_W-1:0]  out_weight
);

  a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_status == lcsf_pkg::ST_OK)))
    else $error("accepted flag disagrees with status");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |-> (out_filtered_count == '0 && out_weight == '0))
    else $error("rejected result carries nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                 $stable(out_accepted) && $stable(out_weight) &&
                                 $stable(out_filtered_count)))
    else $error("stalled result changed");

  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side can drain");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind load_cell_sample_filter lcsf_checker u_lcsf_checker (.*);

`default_nettype wire

### tb/sv/load_cell_sample_filter_checker.sv
// Checker for the load cell sample filter: predicts every reading and compares results.
`timescale 1ns / 100ps

module load_cell_sample_filter_checker #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [lcsf_pkg::RAW_W-1:0]            in_raw_code,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic                                  out_accepted,
  input  logic [1:0]                            out_status,
  input  logic signed [lcsf_pkg::RAW_W-1:0]     out_filtered_count,
  input  logic signed [lcsf_pkg::WEIGHT_W-1:0]  out_weight,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [lcsf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lcsf_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                    failures,
  output int                                    pending
);

  typedef struct {
    logic                                 accepted;
    lcsf_pkg::status_t                    status;
    logic signed [lcsf_pkg::RAW_W-1:0]    filt;
    logic signed [lcsf_pkg::WEIGHT_W-1:0] weight;
  } reading_t;

  reading_t                            predicted_readings[$];
  reading_t                            want;
  logic signed [lcsf_pkg::OFF_W-1:0]   tare_offset;
  logic signed [lcsf_pkg::RAW_W-1:0]   tare_fill;
  logic [lcsf_pkg::SCALE_W-1:0]        lbs_scale;
  logic signed [lcsf_pkg::RAW_W-1:0]   window_codes[WINDOW_LEN];
  int                                  slot;
  logic                                window_full;

  function automatic reading_t filter_sample(logic [lcsf_pkg::RAW_W-1:0] raw);
    reading_t r;
    longint   v;
    longint   mag;
    longint   sum;
    longint   filt_l;
    longint   diff;
    longint   scale_l;
    longint   prod;
    longint   shifted;
    r.accepted = 1'b0;
    r.status   = lcsf_pkg::ST_OK;
    r.filt     = '0;
    r.weight   = '0;
    v   = -longint'($signed(raw));
    mag = (v < 0) ? -v : v;
    if (v == 0 || v == longint'(lcsf_pkg::MINUS_ONE) ||
        v == longint'(lcsf_pkg::GLITCH_POS) ||
        v == longint'(lcsf_pkg::GLITCH_NEG)) begin
      r.status = lcsf_pkg::ST_GLITCH;
    end else if (mag < longint'(lcsf_pkg::MAG_MIN) ||
                 mag > longint'(lcsf_pkg::MAG_MAX)) begin
      r.status = lcsf_pkg::ST_RANGE;
    end else begin
      window_codes[slot] = v[lcsf_pkg::RAW_W-1:0];
      slot = (slot + 1) % WINDOW_LEN;
      if (!window_full && slot == 0) window_full = 1'b1;
      if (window_full) begin
        sum = 0;
        for (int i = 0; i < WINDOW_LEN; i++) sum += longint'(window_codes[i]);
        filt_l = sum / longint'(WINDOW_LEN);
      end else begin
        filt_l = v;
      end
      diff     = filt_l - longint'(tare_offset);
      scale_l  = {32'b0, lbs_scale};
      prod     = diff * scale_l;
      shifted  = prod >>> 16;
      r.accepted = 1'b1;
      r.filt     = filt_l[lcsf_pkg::RAW_W-1:0];
      r.weight   = shifted[lcsf_pkg::WEIGHT_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tare_offset = '0;
      lbs_scale   = lcsf_pkg::SCALE_RESET;
      for (int i = 0; i < WINDOW_LEN; i++) window_codes[i] = '0;
      slot        = 0;
      window_full = 1'b0;
      predicted_readings.delete();
      failures    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lcsf_pkg::REG_ZERO_OFFSET: begin
            tare_offset = cfg_data[lcsf_pkg::OFF_W-1:0];
            if (tare_offset > lcsf_pkg::CODE_MAX) tare_fill = lcsf_pkg::CODE_MAX;
            else if (tare_offset < lcsf_pkg::CODE_MIN) tare_fill = lcsf_pkg::CODE_MIN;
            else tare_fill = tare_offset[lcsf_pkg::RAW_W-1:0];
            for (int i = 0; i < WINDOW_LEN; i++) window_codes[i] = tare_fill;
            slot        = 0;
            window_full = 1'b0;
          end
          lcsf_pkg::REG_LBS_PER_COUNT: lbs_scale = cfg_data[lcsf_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predicted_readings.push_back(filter_sample(in_raw_code));
      if (out_valid && !out_stall) begin
        if (predicted_readings.size() == 0) begin
          $error("unexpected result: status %0d, filtered_count %0d, weight %0d",
                 out_status, out_filtered_count, out_weight);
          failures++;
        end else begin
          want = predicted_readings.pop_front();
          if (out_accepted !== want.accepted) begin
            $error("out_accepted: expected %0d, got %0d", want.accepted, out_accepted);
            failures++;
          end
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            failures++;
          end
          if (out_filtered_count !== want.filt) begin
            $error("out_filtered_count: expected %0d, got %0d", want.filt,
                   out_filtered_count);
            failures++;
          end
          if (out_weight !== want.weight) begin
            $error("out_weight: expected %0d, got %0d", want.weight, out_weight);
            failures++;
          end
        end
      end
    end
    pending = predicted_readings.size();
  end

endmodule

### tb/sv/load_cell_sample_filter_test.sv
// Testbench top for the load cell sample filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module load_cell_sample_filter_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_PHASE    = 2;

  localparam logic [lcsf_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [lcsf_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                                     clk;
  logic                                     rst_n;
  logic                                     in_valid;
  logic                                     in_stall;
  logic [lcsf_pkg::RAW_W-1:0]               in_raw_code;
  logic                                     out_valid;
  logic                                     out_stall;
  logic                                     out_accepted;
  logic [1:0]                               out_status;
  logic signed [lcsf_pkg::RAW_W-1:0]        out_filtered_count;
  logic signed [lcsf_pkg::WEIGHT_W-1:0]     out_weight;
  logic                                     cfg_valid;
  logic                                     cfg_ready;
  logic [lcsf_pkg::CFG_IDX_W-1:0]           cfg_index;
  logic [lcsf_pkg::CFG_DATA_W-1:0]          cfg_data;
  int                                       failure_count;
  int                                       pending_readings;
  int                                       phase;
  int                                       burst_left;
  int                                       cycle_count;

  load_cell_sample_filter dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_raw_code,
    .out_valid, .out_stall, .out_accepted, .out_status, .out_filtered_count, .out_weight,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  load_cell_sample_filter_checker checker_i (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_raw_code,
    .out_valid, .out_stall, .out_accepted, .out_status, .out_filtered_count, .out_weight,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .failures(failure_count), .pending(pending_readings)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int  pct;
    int  run;
    int  hold;
    bit  held;
    out_stall = 1'b0;
    pct  = 0;
    run  = 0;
    hold = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!held && phase == HOLD_PHASE) begin
        held = 1'b1;
        hold = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (run == 0) begin
          run = $urandom_range(100, 20);
          case ($urandom_range(3, 0))
            0: pct = 0;
            1: pct = 25;
            2: pct = 60;
            default: pct = 90;
          endcase
        end
        run--;
        out_stall <= ($urandom_range(99, 0) < pct);
      end
    end
  end

  function automatic logic [lcsf_pkg::RAW_W-1:0] code_for(int v);
    int n;
    n = -v;
    return n[lcsf_pkg::RAW_W-1:0];
  endfunction

  function automatic logic [lcsf_pkg::RAW_W-1:0] random_code();
    int sel;
    int mag;
    sel = $urandom_range(99, 0);
    if (sel < 60) begin
      mag = ($urandom_range(3, 0) == 0) ? $urandom_range(8000000, 100)
                                        : $urandom_range(20000, 100);
      return code_for($urandom_range(1, 0) ? mag : -mag);
    end else if (sel < 72) begin
      case ($urandom_range(3, 0))
        0: mag = 99;
        1: mag = 100;
        2: mag = 8000000;
        default: mag = 8000001;
      endcase
      return code_for($urandom_range(1, 0) ? mag : -mag);
    end else if (sel < 80) begin
      case ($urandom_range(2, 0))
        0: return 24'h000000;
        1: return 24'h000001;
        default: return 24'h800001;
      endcase
    end
    return lcsf_pkg::RAW_W'($urandom());
  endfunction

  // hold valid and payload until the request is taken
  task automatic send_code(logic [lcsf_pkg::RAW_W-1:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_raw_code <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [lcsf_pkg::CFG_IDX_W-1:0] idx,
                           logic [lcsf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    while (pending_readings != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(int p);
    logic [lcsf_pkg::CFG_DATA_W-1:0] r;
    int                              off;
    r = $urandom();
    case (p)
      1: begin
        cfg_write(REG_SPARE_A, $urandom());
        cfg_write(lcsf_pkg::REG_LBS_PER_COUNT, lcsf_pkg::SCALE_RESET);
        cfg_write(lcsf_pkg::REG_ZERO_OFFSET, 32'd0);
      end
      2: begin
        cfg_write(lcsf_pkg::REG_LBS_PER_COUNT, 32'hFFFF_FFFF);
        cfg_write(lcsf_pkg::REG_ZERO_OFFSET, 32'(-8388608));
      end
      3: begin
        cfg_write(lcsf_pkg::REG_LBS_PER_COUNT, 32'd0);
        cfg_write(lcsf_pkg::REG_ZERO_OFFSET, 32'd8388608);
      end
      4: begin
        off = int'($urandom_range(16777216, 0)) - 8388608;
        cfg_write(REG_SPARE_B, $urandom());
        cfg_write(lcsf_pkg::REG_LBS_PER_COUNT, 32'd1);
        cfg_write(lcsf_pkg::REG_ZERO_OFFSET, 32'(off));
      end
      5: cfg_write(lcsf_pkg::REG_LBS_PER_COUNT, $urandom());
      6: begin
        cfg_write(lcsf_pkg::REG_LBS_PER_COUNT, 32'hFFFF_FFFF);
        cfg_write(lcsf_pkg::REG_ZERO_OFFSET,
                  {{(lcsf_pkg::CFG_DATA_W-lcsf_pkg::OFF_W){r[lcsf_pkg::OFF_W-1]}},
                   r[lcsf_pkg::OFF_W-1:0]});
      end
      7: begin
        off = int'($urandom_range(2000, 0)) - 1000;
        cfg_write(lcsf_pkg::REG_LBS_PER_COUNT, $urandom());
        cfg_write(lcsf_pkg::REG_ZERO_OFFSET, 32'(off));
      end
      default: begin
        off = int'($urandom_range(16777216, 0)) - 8388608;
        cfg_write(REG_SPARE_A, $urandom());
        cfg_write(lcsf_pkg::REG_LBS_PER_COUNT, lcsf_pkg::SCALE_RESET);
        cfg_write(lcsf_pkg::REG_ZERO_OFFSET, 32'(off));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [lcsf_pkg::RAW_W-1:0] directed_codes[$];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_raw_code = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    phase       = 0;
    burst_left  = 0;
    directed_codes = '{24'h000000, 24'h000001, 24'h800001, 24'hFFFFFF, 24'h800000,
                       24'h7FFFFF};
    directed_codes.push_back(code_for(99));
    directed_codes.push_back(code_for(100));
    directed_codes.push_back(code_for(-99));
    directed_codes.push_back(code_for(-100));
    directed_codes.push_back(code_for(8000000));
    directed_codes.push_back(code_for(8000001));
    directed_codes.push_back(code_for(-8000000));
    directed_codes.push_back(code_for(-8000001));
    directed_codes.push_back(code_for(8000000));
    directed_codes.push_back(code_for(8000000));
    directed_codes.push_back(code_for(-8000000));
    directed_codes.push_back(code_for(5000));
    directed_codes.push_back(code_for(-5000));
    directed_codes.push_back(code_for(123456));
    directed_codes.push_back(code_for(8000000));
    directed_codes.push_back(code_for(-777));
    directed_codes.push_back(24'h000000);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_codes[i]) send_code(directed_codes[i]);
    for (int p = 1; p <= PHASES; p++) begin
      in_valid <= 1'b0;
      settle();
      configure(p);
      phase = p;
      repeat (PHASE_ITEMS) send_code(random_code());
    end
    in_valid <= 1'b0;
    settle();
    if (failure_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
